### sv/srm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants for step_response_metrics
// Result record, register indexes and fixed-point limits.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_BAND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 1'b1;

  localparam logic [30:0] SETTLE_BAND_RESET = 31'd65536;
  localparam logic [31:0] TIMEOUT_RESET     = 32'hFFFF_FFFF;

  localparam logic [30:0]        Q_MAX_POS = 31'h7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0]        settle_time;
    logic [30:0]        overshoot;
    logic [30:0]        largest_positive_local_min;
    logic [30:0]        largest_positive_local_max;
    logic signed [31:0] max_speed;
  } result_t;

endpackage

### sv/srm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_core: sample register, run state and metric update
// Holds one accepted sample, folds it into the running metrics and
// produces the result record when the sample closes a run.
// ----------------------------------------------------------------------------
module srm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [31:0]         sample_time,
  input  logic signed [31:0]  position,
  input  logic signed [31:0]  speed,
  input  logic                last_sample,
  input  logic [30:0]         settle_band,
  input  logic [31:0]         timeout_time,
  input  logic                res_blocked,
  output logic                res_load,
  output srm_pkg::result_t    res
);
  import srm_pkg::*;

  // sample register
  logic               s1_valid;
  logic [31:0]        s1_time;
  logic signed [31:0] s1_pos;
  logic signed [31:0] s1_speed;
  logic               s1_last;

  // run state
  logic signed [31:0] older_position;
  logic signed [31:0] newer_position;
  logic [1:0]         samples_seen;
  logic [31:0]        last_outside_time;
  logic signed [31:0] lowest_position;
  logic signed [31:0] best_local_min;
  logic signed [31:0] best_local_max;
  logic signed [31:0] peak_speed;

  logic               advance;
  logic               take;
  logic [31:0]        abs_pos;
  logic               outside;
  logic [31:0]        last_outside_time_next;
  logic signed [31:0] lowest_position_next;
  logic signed [31:0] peak_speed_next;
  logic signed [31:0] best_local_min_next;
  logic signed [31:0] best_local_max_next;
  logic               window_full;
  logic               mid_pos;
  logic [31:0]        neg_low;

  // a run-closing sample waits while the result register is occupied and stalled
  assign advance      = s1_valid && !(s1_last && res_blocked);
  assign sample_stall = s1_valid && !advance;
  assign take         = sample_valid && !sample_stall;
  assign res_load     = advance && s1_last;

  always_comb begin
    if (s1_pos == S32_MIN) begin
      abs_pos = {1'b0, Q_MAX_POS};
    end else if (s1_pos < 0) begin
      abs_pos = 32'(-s1_pos);
    end else begin
      abs_pos = s1_pos;
    end
  end

  assign outside = abs_pos > {1'b0, settle_band};

  always_comb begin
    if (samples_seen == 2'd0) begin
      last_outside_time_next = s1_time;
    end else if (outside && !s1_last) begin
      last_outside_time_next = s1_time;
    end else begin
      last_outside_time_next = last_outside_time;
    end
  end

  assign lowest_position_next = (s1_pos < lowest_position) ? s1_pos : lowest_position;
  assign peak_speed_next      = (s1_speed > peak_speed) ? s1_speed : peak_speed;

  // extrema test on the middle of the three-sample window
  assign window_full = samples_seen[1];
  assign mid_pos     = newer_position > 32'sd0;

  always_comb begin
    best_local_min_next = best_local_min;
    best_local_max_next = best_local_max;
    if (window_full && mid_pos && newer_position < older_position &&
        newer_position < s1_pos && newer_position > best_local_min) begin
      best_local_min_next = newer_position;
    end
    if (window_full && mid_pos && newer_position > older_position &&
        newer_position > s1_pos && newer_position > best_local_max) begin
      best_local_max_next = newer_position;
    end
  end

  assign neg_low = 32'(-lowest_position_next);

  always_comb begin
    res.settle_time = outside ? timeout_time : last_outside_time_next;
    res.overshoot   = (lowest_position_next == S32_MIN) ? Q_MAX_POS : neg_low[30:0];
    res.largest_positive_local_min = best_local_min_next[30:0];
    res.largest_positive_local_max = best_local_max_next[30:0];
    res.max_speed   = peak_speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_time  <= sample_time;
      s1_pos   <= position;
      s1_speed <= speed;
      s1_last  <= last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && s1_last)) begin
      older_position    <= '0;
      newer_position    <= '0;
      samples_seen      <= 2'd0;
      last_outside_time <= '0;
      lowest_position   <= '0;
      best_local_min    <= '0;
      best_local_max    <= '0;
      peak_speed        <= S32_MIN;
    end else if (advance) begin
      older_position    <= newer_position;
      newer_position    <= s1_pos;
      if (!samples_seen[1]) begin
        samples_seen <= samples_seen + 2'd1;
      end
      last_outside_time <= last_outside_time_next;
      lowest_position   <= lowest_position_next;
      best_local_min    <= best_local_min_next;
      best_local_max    <= best_local_max_next;
      peak_speed        <= peak_speed_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    samples_seen != 2'd3)
    else $error("sample count out of range");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    res_load |=> samples_seen == 2'd0 && peak_speed == S32_MIN)
    else $error("run state not cleared after result");

  a_extrema_nonneg: assert property (@(posedge clk) disable iff (rst)
    !best_local_min[31] && !best_local_max[31])
    else $error("extrema sign broken");

  a_low_nonpos: assert property (@(posedge clk) disable iff (rst)
    lowest_position <= 32'sd0)
    else $error("lowest position above zero");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> s1_valid && s1_last && res_blocked)
    else $error("stall without a blocked result");

endmodule

### sv/srm_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_out_reg: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module srm_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  srm_pkg::result_t  res,
  output logic              res_blocked,
  output logic              result_valid,
  input  logic              result_stall,
  output srm_pkg::result_t  result
);
  import srm_pkg::*;

  assign res_blocked = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // core only loads when the register is free or being emptied
  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule

### sv/step_response_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_response_metrics: step response scoring
// Reads trajectory samples and reports five metrics at the end of each run.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid / sample_stall) carries time, position,
//   speed and last_sample. One item is taken per cycle while sample_stall is
//   low; runs are framed by last_sample. Only the last item of a run yields a
//   result item on the result channel (result_valid / result_stall).
//   A result passes through the sample register and then the result register.
//   Throughput: one sample per cycle while sample_stall is low, set by the
//   single sample register feeding the metric update.
//   Stall: a held result keeps its fields; non-final samples keep flowing,
//   and the next run-closing sample waits in the sample register, which then
//   raises sample_stall.
//   Reset (rst, synchronous): clears run state and restores settle_band to
//   1.0 and timeout_time to all ones. Write settle_band / timeout_time via
//   cfg_write only while no run is in flight.
// ----------------------------------------------------------------------------
module step_response_metrics (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [srm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [srm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [31:0]                       sample_time,
  input  logic signed [31:0]                position,
  input  logic signed [31:0]                speed,
  input  logic                              last_sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [31:0]                       settle_time,
  output logic [30:0]                       overshoot,
  output logic [30:0]                       largest_positive_local_min,
  output logic [30:0]                       largest_positive_local_max,
  output logic signed [31:0]                max_speed
);
  import srm_pkg::*;

  logic [30:0] settle_band;
  logic [31:0] timeout_time;
  logic        res_blocked;
  logic        res_load;
  result_t     res;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_band  <= SETTLE_BAND_RESET;
      timeout_time <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETTLE_BAND: settle_band  <= cfg_data[30:0];
        REG_TIMEOUT:     timeout_time <= cfg_data;
        default: ;
      endcase
    end
  end

  srm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_time  (sample_time),
    .position     (position),
    .speed        (speed),
    .last_sample  (last_sample),
    .settle_band  (settle_band),
    .timeout_time (timeout_time),
    .res_blocked  (res_blocked),
    .res_load     (res_load),
    .res          (res)
  );

  srm_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .res_blocked  (res_blocked),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign settle_time                = result.settle_time;
  assign overshoot                  = result.overshoot;
  assign largest_positive_local_min = result.largest_positive_local_min;
  assign largest_positive_local_max = result.largest_positive_local_max;
  assign max_speed                  = result.max_speed;

endmodule
